FILE: hw/rtl/brb_pkg.sv
// Shared constants, word codes and types for the three-cursor byte ring buffer.
// Used by every module under hw/rtl except brb_ram; depends on nothing.
package brb_pkg;

    // Storage geometry
    localparam int DEPTH          = 4096;
    localparam int BYTES_PER_ITEM = 8;
    localparam int ADDR_W         = $clog2(DEPTH);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int LANE_W         = 3;
    localparam int BANKS          = 1 << LANE_W;
    localparam int ROW_W          = ADDR_W - LANE_W;
    localparam int BANK_DEPTH     = DEPTH / BANKS;
    localparam int DATA_W         = 8 * BANKS;
    localparam int N_W            = LANE_W + 1;

    // Operation codes carried in func
    localparam logic [2:0] FN_PUSH    = 3'd0;
    localparam logic [2:0] FN_POP     = 3'd1;
    localparam logic [2:0] FN_DISCARD = 3'd2;
    localparam logic [2:0] FN_ADVW    = 3'd3;
    localparam logic [2:0] FN_ADVU    = 3'd4;
    localparam logic [2:0] FN_CLEAR   = 3'd5;
    localparam logic [2:0] FN_STATUS  = 3'd6;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEG1,
        ST_SEG2,
        ST_CAPT,
        ST_DONE
    } state_t;

    // One contiguous run of bytes in the store
    typedef struct packed {
        logic [ADDR_W-1:0] start;  // first byte position
        logic [N_W-1:0]    n;      // bytes in the run
        logic [N_W-1:0]    off;    // byte lane of the word where the run begins
    } seg_t;

    // Decision for the word under evaluation
    typedef struct packed {
        logic           ok;
        logic           xfer;      // accepted push or pop, needs the store
        logic           pop;
        seg_t           seg1;
        logic [N_W-1:0] seg2_n;    // bytes after the wrap, from position zero
    } eval_t;

    // Counts and cursor views after an operation
    typedef struct packed {
        logic [CNT_W-1:0]  free_bytes;
        logic [CNT_W-1:0]  use_bytes;
        logic [ADDR_W-1:0] write_pos;
        logic [CNT_W-1:0]  write_span;
        logic [ADDR_W-1:0] read_pos;
        logic [CNT_W-1:0]  read_span;
        logic [ADDR_W-1:0] use_pos;
        logic [CNT_W-1:0]  use_span;
    } status_t;

endpackage

FILE: hw/rtl/byte_ring_buffer_three_cursor_top.sv
// Top level of the three-cursor byte ring buffer: word sequencer, result register.
// Depends on brb_pkg, brb_ctrl and brb_banks.
//
// Each input word is one operation on a byte ring of up to 4096 bytes. A word that needs
// no data (discard, advance write, advance use, clear, status and any rejected word) goes
// through three steps before the next acceptance: accept, evaluate, load the result
// register. An accepted push adds a store write before the load, and an accepted pop a
// store read and a capture, with a second store access for either when the bytes cross the
// capacity boundary: the store is eight byte banks with one port each.
// The result register lets the next word be accepted while the last result still
// waits to be taken. Writing capacity returns the buffer to empty; the user must write it
// only while the block is idle, which the block itself does not enforce. Popping bytes
// that were committed by advance write but never pushed returns undefined data.
module byte_ring_buffer_three_cursor_top
    import brb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        func,
    input  logic [CNT_W-1:0]  length,
    input  logic [DATA_W-1:0] data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [DATA_W-1:0] read_data,
    output logic [CNT_W-1:0]  free_bytes,
    output logic [CNT_W-1:0]  use_bytes,
    output logic [ADDR_W-1:0] write_pos,
    output logic [CNT_W-1:0]  write_span,
    output logic [ADDR_W-1:0] read_pos,
    output logic [CNT_W-1:0]  read_span,
    output logic [ADDR_W-1:0] use_pos,
    output logic [CNT_W-1:0]  use_span
);

    state_t            state_reg, state_next;
    logic              out_valid_reg;
    logic [2:0]        func_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [DATA_W-1:0] data_reg;
    seg_t              seg1_reg;
    logic [N_W-1:0]    seg2_n_reg;
    logic              pop_reg;
    logic              ok_hold_reg;
    logic [DATA_W-1:0] rd_acc_reg;
    logic              res_ok_reg;
    logic [DATA_W-1:0] res_rd_reg;
    status_t           res_st_reg;

    eval_t             ev;
    status_t           st;
    seg_t              seg2;
    seg_t              seg_sel;
    logic              eval_en, acc_en, capt, load_out;
    logic [DATA_W-1:0] rd_word;

    brb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .eval_en  (eval_en),
        .func     (func_reg),
        .length   (len_reg),
        .ev       (ev),
        .st       (st)
    );

    brb_banks u_banks (
        .clk     (clk),
        .acc_en  (acc_en),
        .acc_we  (!pop_reg),
        .seg     (seg_sel),
        .wdata   (data_reg),
        .rd_word (rd_word)
    );

    // Second run always starts at position zero, after the first run's bytes
    always_comb
    begin
        seg2.start = '0;
        seg2.n     = seg2_n_reg;
        seg2.off   = seg1_reg.n;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        eval_en    = 1'b0;
        acc_en     = 1'b0;
        capt       = 1'b0;
        load_out   = 1'b0;
        seg_sel    = seg1_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                eval_en    = 1'b1;
                state_next = ev.xfer ? ST_SEG1 : ST_DONE;
            end
            ST_SEG1:
            begin
                acc_en = 1'b1;
                if (seg2_n_reg != '0)
                    state_next = ST_SEG2;
                else
                    state_next = pop_reg ? ST_CAPT : ST_DONE;
            end
            ST_SEG2:
            begin
                acc_en     = 1'b1;
                seg_sel    = seg2;
                capt       = pop_reg;
                state_next = pop_reg ? ST_CAPT : ST_DONE;
            end
            ST_CAPT:
            begin
                capt       = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Word, transfer plan and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            len_reg  <= length;
            data_reg <= data;
        end
        if (eval_en)
        begin
            seg1_reg    <= ev.seg1;
            seg2_n_reg  <= ev.seg2_n;
            pop_reg     <= ev.pop;
            ok_hold_reg <= ev.ok;
            rd_acc_reg  <= '0;
        end
        else if (capt)
            rd_acc_reg <= rd_acc_reg | rd_word;
        if (load_out)
        begin
            res_ok_reg <= ok_hold_reg;
            res_rd_reg <= rd_acc_reg;
            res_st_reg <= st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = res_ok_reg;
    assign read_data  = res_rd_reg;
    assign free_bytes = res_st_reg.free_bytes;
    assign use_bytes  = res_st_reg.use_bytes;
    assign write_pos  = res_st_reg.write_pos;
    assign write_span = res_st_reg.write_span;
    assign read_pos   = res_st_reg.read_pos;
    assign read_span  = res_st_reg.read_span;
    assign use_pos    = res_st_reg.use_pos;
    assign use_span   = res_st_reg.use_span;

    // Checks
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EVAL)
        else $error("accepted word not evaluated next cycle");

    a_run_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEG1 |-> (seg1_reg.n != '0)
        && ((seg1_reg.n + seg2_n_reg) <= N_W'(BYTES_PER_ITEM)))
        else $error("transfer runs out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !out_ready |=> state_reg == ST_DONE)
        else $error("result register overwritten while still waiting");

endmodule

FILE: hw/rtl/brb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/brb_banks.sv
// Eight byte-wide banks of the store, with run-to-lane steering for writes
// and reads. Depends on brb_pkg and brb_ram.
module brb_banks
    import brb_pkg::*;
(
    input  logic              clk,
    input  logic              acc_en,
    input  logic              acc_we,
    input  seg_t              seg,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rd_word
);

    logic [LANE_W-1:0] lane_j   [BANKS];
    logic              lane_hit [BANKS];
    logic [ROW_W-1:0]  lane_row [BANKS];
    logic [7:0]        lane_wd  [BANKS];
    logic [7:0]        bank_q   [BANKS];
    seg_t              rseg_reg;

    // Per bank: which byte of the run lands here, and in which row
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            lane_j[b]   = LANE_W'(b) - seg.start[LANE_W-1:0];
            lane_hit[b] = {1'b0, lane_j[b]} < seg.n;
            lane_row[b] = seg.start[ADDR_W-1:LANE_W]
                        + ROW_W'(LANE_W'(b) < seg.start[LANE_W-1:0]);
            lane_wd[b]  = wdata[8*LANE_W'(seg.off[LANE_W-1:0] + lane_j[b]) +: 8];
        end
    end

    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        brb_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (acc_en && lane_hit[g]),
            .we    (acc_we),
            .addr  (lane_row[g]),
            .wdata (lane_wd[g]),
            .rdata (bank_q[g])
        );
    end

    // Remember the run of the read in flight
    always_ff @(posedge clk)
    begin
        if (acc_en && !acc_we)
            rseg_reg <= seg;
    end

    // Place the returned bytes on their word lanes, zero elsewhere
    always_comb
    begin
        logic [N_W-1:0]    jj;
        logic [LANE_W-1:0] bk;
        for (int i = 0; i < BANKS; i++)
        begin
            jj = N_W'(i) - rseg_reg.off;
            bk = rseg_reg.start[LANE_W-1:0] + jj[LANE_W-1:0];
            if ((N_W'(i) >= rseg_reg.off) && (jj < rseg_reg.n))
                rd_word[8*i +: 8] = bank_q[bk];
            else
                rd_word[8*i +: 8] = 8'h00;
        end
    end

endmodule

FILE: hw/rtl/brb_ctrl.sv
// Cursor, count and wrap-flag registers with the per-operation decision
// and the status view. Depends on brb_pkg.
module brb_ctrl
    import brb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             eval_en,
    input  logic [2:0]       func,
    input  logic [CNT_W-1:0] length,
    output eval_t            ev,
    output status_t          st
);

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [ADDR_W-1:0] wr_reg, wr_next;
    logic [ADDR_W-1:0] rd_reg, rd_next;
    logic [ADDR_W-1:0] use_reg, use_next;
    logic              wwrap_reg, wwrap_next;
    logic              uwrap_reg, uwrap_next;

    logic [CNT_W-1:0]  cap_new;
    logic [CNT_W-1:0]  used;
    logic              len_nz, len_small, fit_free, fit_used;
    logic [CNT_W:0]    wr_sum, rd_sum, use_sum, use_nu;
    logic              wr_cross, rd_cross, use_cross;
    logic [ADDR_W-1:0] wr_adv, rd_adv;
    logic [ADDR_W-1:0] xfer_base;
    logic [CNT_W-1:0]  first;
    logic              empty;
    logic              acc_ok;

    // Capacity write: clamp into 1..DEPTH
    always_comb
    begin
        if (cfg_data == '0)
            cap_new = CNT_W'(1);
        else if (cfg_data > CNT_W'(DEPTH))
            cap_new = CNT_W'(DEPTH);
        else
            cap_new = cfg_data;
    end

    // Length checks and cursor advances
    assign used      = cap_reg - free_reg;
    assign len_nz    = length != '0;
    assign len_small = length <= CNT_W'(BYTES_PER_ITEM);
    assign fit_free  = length <= free_reg;
    assign fit_used  = length <= used;

    assign wr_sum   = {2'b00, wr_reg} + {1'b0, length};
    assign wr_cross = wr_sum >= {1'b0, cap_reg};
    assign wr_adv   = wr_cross ? ADDR_W'(wr_sum - {1'b0, cap_reg}) : wr_sum[ADDR_W-1:0];
    assign rd_sum   = {2'b00, rd_reg} + {1'b0, length};
    assign rd_cross = rd_sum >= {1'b0, cap_reg};
    assign rd_adv   = rd_cross ? ADDR_W'(rd_sum - {1'b0, cap_reg}) : rd_sum[ADDR_W-1:0];
    assign use_sum   = {2'b00, use_reg} + {1'b0, length};
    assign use_cross = use_sum >= {1'b0, cap_reg};
    assign use_nu    = use_sum - {1'b0, cap_reg};

    // Next state and acceptance
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        use_next   = use_reg;
        free_next  = free_reg;
        wwrap_next = wwrap_reg;
        uwrap_next = uwrap_reg;
        acc_ok     = 1'b0;
        unique case (func) inside
            FN_PUSH, FN_ADVW:
            begin
                if (len_nz && fit_free && (func == FN_ADVW || len_small))
                begin
                    acc_ok    = 1'b1;
                    wr_next   = wr_adv;
                    free_next = free_reg - length;
                    if (wr_cross)
                    begin
                        wwrap_next = 1'b1;
                        uwrap_next = 1'b1;
                    end
                end
            end
            FN_POP, FN_DISCARD:
            begin
                if (len_nz && fit_used && (func == FN_DISCARD || len_small))
                begin
                    acc_ok    = 1'b1;
                    rd_next   = rd_adv;
                    free_next = free_reg + length;
                    if (rd_cross)
                        wwrap_next = 1'b0;
                end
            end
            FN_ADVU:
            begin
                if (len_nz && fit_used)
                begin
                    if (uwrap_reg)
                    begin
                        if (!use_cross)
                        begin
                            acc_ok   = 1'b1;
                            use_next = use_sum[ADDR_W-1:0];
                        end
                        else if (use_nu <= {2'b00, wr_reg})
                        begin
                            acc_ok     = 1'b1;
                            use_next   = use_nu[ADDR_W-1:0];
                            uwrap_next = 1'b0;
                        end
                    end
                    else if (use_sum <= {2'b00, wr_reg})
                    begin
                        acc_ok   = 1'b1;
                        use_next = use_sum[ADDR_W-1:0];
                    end
                end
            end
            FN_CLEAR:
            begin
                acc_ok     = 1'b1;
                wr_next    = '0;
                rd_next    = '0;
                use_next   = '0;
                free_next  = cap_reg;
                wwrap_next = 1'b0;
                uwrap_next = 1'b0;
            end
            FN_STATUS:
                acc_ok = 1'b1;
            default:
                acc_ok = 1'b0;
        endcase
    end

    // Split a transfer at the capacity boundary into at most two runs
    assign xfer_base = (func == FN_POP) ? rd_reg : wr_reg;
    assign first     = cap_reg - {1'b0, xfer_base};
    always_comb
    begin
        ev.ok         = acc_ok;
        ev.xfer       = acc_ok && (func == FN_PUSH || func == FN_POP);
        ev.pop        = func == FN_POP;
        ev.seg1.start = xfer_base;
        ev.seg1.off   = '0;
        if (length <= first)
        begin
            ev.seg1.n = length[N_W-1:0];
            ev.seg2_n = '0;
        end
        else
        begin
            ev.seg1.n = first[N_W-1:0];
            ev.seg2_n = length[N_W-1:0] - first[N_W-1:0];
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            free_reg  <= CNT_W'(DEPTH);
            wr_reg    <= '0;
            rd_reg    <= '0;
            use_reg   <= '0;
            wwrap_reg <= 1'b0;
            uwrap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_new;
            free_reg  <= cap_new;
            wr_reg    <= '0;
            rd_reg    <= '0;
            use_reg   <= '0;
            wwrap_reg <= 1'b0;
            uwrap_reg <= 1'b0;
        end
        else if (eval_en)
        begin
            free_reg  <= free_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            use_reg   <= use_next;
            wwrap_reg <= wwrap_next;
            uwrap_reg <= uwrap_next;
        end
    end

    // Status view of the current registers (counts modulo 2^13)
    assign empty = free_reg == cap_reg;
    always_comb
    begin
        st.free_bytes = free_reg;
        st.write_pos  = wr_reg;
        st.read_pos   = rd_reg;
        st.use_pos    = use_reg;

        if (empty)
            st.use_bytes = '0;
        else if (uwrap_reg)
            st.use_bytes = cap_reg + {1'b0, wr_reg} - {1'b0, use_reg};
        else
            st.use_bytes = {1'b0, wr_reg} - {1'b0, use_reg};

        if (free_reg == '0)
            st.write_span = '0;
        else if (wwrap_reg)
            st.write_span = {1'b0, rd_reg} - {1'b0, wr_reg};
        else
            st.write_span = cap_reg - {1'b0, wr_reg};

        if (empty)
            st.read_span = '0;
        else if (wwrap_reg)
            st.read_span = cap_reg - {1'b0, rd_reg};
        else
            st.read_span = {1'b0, wr_reg} - {1'b0, rd_reg};

        if (empty)
            st.use_span = '0;
        else if (uwrap_reg)
            st.use_span = cap_reg - {1'b0, use_reg};
        else
            st.use_span = {1'b0, wr_reg} - {1'b0, use_reg};
    end

    // Checks
    a_free_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= cap_reg)
        else $error("free count above capacity");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wr_reg} < cap_reg) && ({1'b0, rd_reg} < cap_reg)
        && ({1'b0, use_reg} < cap_reg))
        else $error("cursor at or beyond capacity");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        eval_en && !ev.ok |=> $stable(free_reg) && $stable(wr_reg)
        && $stable(rd_reg) && $stable(use_reg))
        else $error("rejected word changed the buffer state");

endmodule
